// ===== hdl/kalman_force_filter_zeroed_top_assert.svh =====
// Assertion macros for the zeroed Kalman force filter checker.
// Used by kfz_checker.sv; expects clk and arst_n in scope.
`ifndef KALMAN_FORCE_FILTER_ZEROED_TOP_ASSERT_SVH
`define KALMAN_FORCE_FILTER_ZEROED_TOP_ASSERT_SVH

// antecedent in one cycle, consequent in the next
`define KFZ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kfz assertion failed");

// antecedent and consequent in the same cycle
`define KFZ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kfz assertion failed");

`endif

// ===== hdl/kfz_pkg.sv =====
// Shared types, constants and helpers for the zeroed Kalman force filter.
// No dependencies.
package kfz_pkg;
	localparam int FRAC_BITS = 16;
	localparam int AXES      = 3;
	localparam int AX_W      = 2;
	localparam int K_W       = FRAC_BITS + 1;
	localparam int CNT_W     = 5;
	localparam logic [K_W-1:0] K_ONE = K_W'(1) << FRAC_BITS;

	localparam logic [2:0] REG_Q     = 3'd0;
	localparam logic [2:0] REG_R     = 3'd1;
	localparam logic [2:0] REG_P0    = 3'd2;
	localparam logic [2:0] REG_X0    = 3'd3;
	localparam logic [2:0] REG_SX    = 3'd4;
	localparam logic [2:0] REG_SY    = 3'd5;
	localparam logic [2:0] REG_SZ    = 3'd6;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PP, ST_DEN, ST_DIV, ST_KSET, ST_MULK, ST_UPDK,
		ST_MULP, ST_UPDP, ST_BASE, ST_MULO, ST_SATO, ST_DONE
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
		logic signed [31:0] r;
		if (v > 43'sd2147483647) r = 32'sh7fffffff;
		else if (v < -43'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction
endpackage

// ===== hdl/kalman_force_filter_zeroed_top.sv =====
// Zeroed Kalman force filter, top level.
// Depends on kfz_pkg.
//
// Usage: in_data carries one three-axis force sample (signed Q16.16) per
// item on a valid/ready channel; out_data returns one filtered, zeroed and
// scaled sample per input item on a valid/ready channel.
// Each item runs through one shared 34x25 multiplier and a one-bit-per-cycle
// divider under a sequencer; a new item is accepted only after the previous
// one has left the sequencer for the output register. The gain takes 17
// divider steps, and the multiplier makes two passes per axis and one for
// the covariance. in_ready is high only while the sequencer is idle.
// The first filtered sample after reset sets the zero baseline.
// The output register holds a result until out_ready; the next item may be
// accepted meanwhile, and its result waits in the sequencer until the
// output register is free.
// Reset (arst_n low, asynchronous) clears the baseline, drops out_valid and
// resets control, config and estimate state. Configuration writes through
// cfg_we/cfg_idx/cfg_data take effect at once and are meant for idle time.
module kalman_force_filter_zeroed_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  kfz_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output kfz_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_data
);
	import kfz_pkg::*;

	state_t state_q, state_d;

	logic [31:0]        q_q, r_q, cov_q;
	logic [23:0]        scale_q [AXES];
	logic signed [31:0] est_q [AXES];
	logic signed [31:0] base_q [AXES];
	logic signed [31:0] in_q [AXES];
	logic signed [31:0] res_q [AXES];
	logic               taken_q;
	logic [31:0]        pp_q;
	logic [32:0]        den_q;
	logic [33:0]        rem_q;
	logic [K_W-1:0]     quo_q, k_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [AX_W-1:0]    ax_q;
	logic signed [58:0] prod_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [33:0] ma;
	logic signed [24:0] mb;
	logic signed [58:0] mprod;
	logic [33:0]        rsh, rnext;
	logic               ge;
	logic [32:0]        ppsum;
	logic signed [42:0] upd_sum, out_sh;
	logic signed [58:0] out_p;
	logic               last_ax, out_free;

	assign last_ax  = (ax_q == AX_W'(AXES - 1));
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_PP;
			ST_PP:   state_d = ST_DEN;
			ST_DEN:  state_d = ST_DIV;
			ST_DIV:  if (cnt_q == CNT_W'(FRAC_BITS)) state_d = ST_KSET;
			ST_KSET: state_d = ST_MULK;
			ST_MULK: state_d = ST_UPDK;
			ST_UPDK: state_d = last_ax ? ST_MULP : ST_MULK;
			ST_MULP: state_d = ST_UPDP;
			ST_UPDP: state_d = ST_BASE;
			ST_BASE: state_d = ST_MULO;
			ST_MULO: state_d = ST_SATO;
			ST_SATO: state_d = last_ax ? ST_DONE : ST_MULO;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		ma = '0;
		mb = '0;
		case (state_q)
			ST_MULK: begin
				ma = 34'(in_q[ax_q]) - 34'(est_q[ax_q]);
				mb = {8'b0, k_q};
			end
			ST_MULP: begin
				ma = {2'b0, pp_q};
				mb = {8'b0, K_ONE - k_q};
			end
			ST_MULO: begin
				ma = 34'(est_q[ax_q]) - 34'(base_q[ax_q]);
				mb = {1'b0, scale_q[ax_q]};
			end
			default: ;
		endcase
	end

	assign mprod = ma * mb;

	assign ppsum   = {1'b0, cov_q} + {1'b0, q_q};
	assign rsh     = (cnt_q == '0) ? rem_q : {rem_q[32:0], 1'b0};
	assign ge      = (rsh >= {1'b0, den_q});
	assign rnext   = ge ? (rsh - {1'b0, den_q}) : rsh;
	assign upd_sum = 43'(est_q[ax_q]) + 43'(prod_q >>> FRAC_BITS);
	assign out_p   = (ax_q != AX_W'(1)) ? -prod_q : prod_q;
	assign out_sh  = 43'(out_p >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			q_q         <= 32'd655;
			r_q         <= 32'd6554;
			cov_q       <= 32'd65536;
			taken_q     <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			ax_q        <= '0;
			for (int a = 0; a < AXES; a++) begin
				scale_q[a] <= 24'd4588;
				est_q[a]   <= '0;
				base_q[a]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready && state_q != ST_DONE) out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					REG_Q:  q_q <= cfg_data;
					REG_R:  r_q <= cfg_data;
					REG_P0: begin
						cov_q <= cfg_data;
					end
					REG_X0: begin
						for (int a = 0; a < AXES; a++) est_q[a] <= cfg_data;
					end
					REG_SX: scale_q[0] <= cfg_data[23:0];
					REG_SY: scale_q[1] <= cfg_data[23:0];
					REG_SZ: scale_q[2] <= cfg_data[23:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (in_valid) begin
					in_q[0] <= in_data.force_x;
					in_q[1] <= in_data.force_y;
					in_q[2] <= in_data.force_z;
				end
				ST_PP: pp_q <= ppsum[32] ? 32'hffffffff : ppsum[31:0];
				ST_DEN: begin
					den_q <= {1'b0, pp_q} + {1'b0, r_q};
					rem_q <= {2'b0, pp_q};
					cnt_q <= '0;
				end
				ST_DIV: begin
					rem_q <= rnext;
					quo_q <= {quo_q[K_W-2:0], ge};
					cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_KSET: begin
					k_q  <= (quo_q > K_ONE) ? K_ONE : quo_q;
					ax_q <= '0;
				end
				ST_MULK, ST_MULP, ST_MULO: prod_q <= mprod;
				ST_UPDK: begin
					est_q[ax_q] <= sat32(upd_sum);
					ax_q        <= ax_q + AX_W'(1);
				end
				ST_UPDP: cov_q <= prod_q[FRAC_BITS +: 32];
				ST_BASE: begin
					ax_q <= '0;
					if (!taken_q) begin
						for (int a = 0; a < AXES; a++) base_q[a] <= est_q[a];
						taken_q <= 1'b1;
					end
				end
				ST_SATO: begin
					res_q[ax_q] <= sat32(out_sh);
					ax_q        <= ax_q + AX_W'(1);
				end
				ST_DONE: if (out_free) begin
					out_q.out_x <= res_q[0];
					out_q.out_y <= res_q[1];
					out_q.out_z <= res_q[2];
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ===== hdl/kfz_checker.sv =====
// Port-level checker for the zeroed Kalman force filter, bound to the top.
// Depends on kfz_pkg and kalman_force_filter_zeroed_top_assert.svh.
`include "kalman_force_filter_zeroed_top_assert.svh"

module kfz_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input kfz_pkg::out_item_t out_data
);
	import kfz_pkg::*;

	`KFZ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`KFZ_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
	`KFZ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`KFZ_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready,
		!out_valid || $past(out_valid))
endmodule

bind kalman_force_filter_zeroed_top kfz_checker u_kfz_checker (.*);
